// ===== rtl/sgd_pkg.sv =====
// Shared types, constants and exponential tables for the SPH Gaussian density block.
// Used by sgd_kernel and sph_gaussian_density; depends on nothing else.
`timescale 1ns / 1ps

package sgd_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  particle_index;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] particle_mass;
        logic [15:0] smoothing_length;
    } req_t;

    typedef struct packed {
        logic [31:0] density;
        logic        saturated;
    } rsp_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] mass;
        logic [15:0] h;
    } entry_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_READ,
        T_WAIT,
        T_KERN,
        T_FINISH
    } top_state_t;

    typedef enum logic [2:0] {
        K_IDLE,
        K_SQR,
        K_CMP,
        K_DIV,
        K_TAB1,
        K_TAB2,
        K_MASS,
        K_DONE
    } kern_state_t;

    function automatic logic [16:0] exp_int(input logic [4:0] idx);
        logic [16:0] val;
        case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd24109;
            5'd2:    val = 17'd8869;
            5'd3:    val = 17'd3263;
            5'd4:    val = 17'd1200;
            5'd5:    val = 17'd442;
            5'd6:    val = 17'd162;
            5'd7:    val = 17'd60;
            5'd8:    val = 17'd22;
            5'd9:    val = 17'd8;
            5'd10:   val = 17'd3;
            5'd11:   val = 17'd1;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

    function automatic logic [16:0] exp_sixteenth(input logic [3:0] idx);
        logic [16:0] val;
        case (idx)
            4'd0:    val = 17'd65536;
            4'd1:    val = 17'd61565;
            4'd2:    val = 17'd57835;
            4'd3:    val = 17'd54331;
            4'd4:    val = 17'd51039;
            4'd5:    val = 17'd47947;
            4'd6:    val = 17'd45042;
            4'd7:    val = 17'd42313;
            4'd8:    val = 17'd39750;
            4'd9:    val = 17'd37341;
            4'd10:   val = 17'd35079;
            4'd11:   val = 17'd32954;
            4'd12:   val = 17'd30957;
            4'd13:   val = 17'd29081;
            4'd14:   val = 17'd27319;
            default: val = 17'd25664;
        endcase
        return val;
    endfunction

    function automatic logic [16:0] exp_fine(input logic [3:0] idx);
        logic [16:0] val;
        case (idx)
            4'd0:    val = 17'd65536;
            4'd1:    val = 17'd65280;
            4'd2:    val = 17'd65026;
            4'd3:    val = 17'd64772;
            4'd4:    val = 17'd64520;
            4'd5:    val = 17'd64268;
            4'd6:    val = 17'd64018;
            4'd7:    val = 17'd63768;
            4'd8:    val = 17'd63520;
            4'd9:    val = 17'd63272;
            4'd10:   val = 17'd63025;
            4'd11:   val = 17'd62780;
            4'd12:   val = 17'd62535;
            4'd13:   val = 17'd62291;
            4'd14:   val = 17'd62048;
            default: val = 17'd61806;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/sgd_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module sgd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/sgd_kernel.sv =====
// Per-particle Gaussian kernel unit: distance, iterative quotient, table lookup and mass multiply.
// Depends on sgd_pkg for the entry type, state type and exponential tables.
`timescale 1ns / 1ps

module sgd_kernel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sgd_pkg::entry_t entry,
    input  logic [15:0]     qx,
    input  logic [15:0]     qy,
    output logic            term_valid,
    output logic [32:0]     term
);

    import sgd_pkg::*;

    kern_state_t state_reg, state_next;

    logic [15:0] dx_reg, dy_reg, h_reg, mass_reg;
    logic [31:0] dx2_reg, dy2_reg, h2_reg;
    logic [47:0] rem_reg;
    logic [12:0] quo_reg;
    logic [3:0]  bit_reg;
    logic        zero_reg;
    logic [16:0] t_reg, kern_reg;
    logic [32:0] term_reg;

    logic [32:0] d2;
    logic [47:0] num;
    logic [47:0] lim;
    logic [47:0] trial;
    logic [33:0] prod1, prod2;
    logic [33:0] rnd1, rnd2;

    assign d2    = 33'(dx2_reg) + 33'(dy2_reg);
    assign num   = {d2[32:0], 15'd0};
    assign lim   = 48'({h2_reg, 12'd0}) + 48'(h2_reg);
    assign trial = 48'(h2_reg) << bit_reg;
    assign prod1 = 34'(exp_int(quo_reg[12:8])) * 34'(exp_sixteenth(quo_reg[7:4]));
    assign rnd1  = prod1 + 34'd32768;
    assign prod2 = 34'(t_reg) * 34'(exp_fine(quo_reg[3:0]));
    assign rnd2  = prod2 + 34'd32768;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            K_IDLE:  if (start) state_next = K_SQR;
            K_SQR:   state_next = K_CMP;
            K_CMP:   state_next = (num >= lim) ? K_MASS : K_DIV;
            K_DIV:   if (bit_reg == 4'd0) state_next = K_TAB1;
            K_TAB1:  state_next = K_TAB2;
            K_TAB2:  state_next = K_MASS;
            K_MASS:  state_next = K_DONE;
            K_DONE:  state_next = K_IDLE;
            default: state_next = K_IDLE;
        endcase
    end

    always_comb
    begin
        term_valid = (state_reg == K_DONE);
        term       = term_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= K_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            K_IDLE:
            begin
                dx_reg   <= (qx >= entry.x) ? qx - entry.x : entry.x - qx;
                dy_reg   <= (qy >= entry.y) ? qy - entry.y : entry.y - qy;
                h_reg    <= entry.h;
                mass_reg <= entry.mass;
            end
            K_SQR:
            begin
                dx2_reg <= 32'(dx_reg) * 32'(dx_reg);
                dy2_reg <= 32'(dy_reg) * 32'(dy_reg);
                h2_reg  <= 32'(h_reg) * 32'(h_reg);
            end
            K_CMP:
            begin
                rem_reg  <= num;
                quo_reg  <= 13'd0;
                bit_reg  <= 4'd12;
                zero_reg <= (num >= lim);
                kern_reg <= 17'd0;
            end
            K_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    quo_reg <= quo_reg | (13'd1 << bit_reg);
                end
                bit_reg <= bit_reg - 4'd1;
            end
            K_TAB1:
            begin
                t_reg <= rnd1[32:16];
            end
            K_TAB2:
            begin
                kern_reg <= rnd2[32:16];
            end
            K_MASS:
            begin
                term_reg <= zero_reg ? 33'd0 : 33'(mass_reg) * 33'(kern_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/sph_gaussian_density.sv =====
// SPH density summation over a particle table with a Gaussian kernel.
// A request channel accepts particle writes and density queries (valid/stall),
// and a response channel returns one result per query. One configuration
// register holds the number of particles summed by each query.
// A write transfer stores one table entry and gives no response.
// A query transfer walks table entries 0 to particle_count-1 (clamped to the
// table depth); each entry passes through the table read, the 13-step quotient
// loop of the kernel unit and two lookup multiplies, but the loop and lookups
// are skipped when h is zero or the kernel argument passes 16.
// Reset clears the control state and the count register; the table contents
// are undefined until written and no clearing pass is done.
// The response register holds a result until it is taken; a stalled receiver
// holds the result stable, and a new request is accepted meanwhile, but a
// finished query waits for the response register to free up.
`timescale 1ns / 1ps

module sph_gaussian_density #(
    parameter int MAX_PARTICLES = sgd_pkg::MAX_PARTICLES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sgd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sgd_pkg::rsp_t rsp,
    input  logic          cfg_wr_en,
    input  logic [10:0]   cfg_wr_data
);

    import sgd_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int ACC_W = (33 + CNT_W > 41) ? 33 + CNT_W : 41;

    top_state_t state_reg, state_next;

    logic [10:0]      count_reg;
    logic [CNT_W-1:0] n_reg, ptr_reg;
    logic [15:0]      qx_reg, qy_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             accept;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    logic             k_start;
    logic             term_valid;
    logic [32:0]      term;
    logic             last;
    logic             rsp_load;
    logic [CNT_W-1:0] n_clamped;
    logic [ACC_W-9:0] dens_wide;

    assign accept    = req_valid && !req_stall;
    assign last      = (ptr_reg + CNT_W'(1) == n_reg);
    assign n_clamped = (32'(count_reg) > 32'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                            : CNT_W'(count_reg);
    assign dens_wide = acc_reg[ACC_W-1:8];
    assign ram_wdata = '{x: req.pos_x, y: req.pos_y, mass: req.particle_mass,
                         h: req.smoothing_length};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept && req.req_type == REQ_QUERY)
                begin
                    state_next = (n_clamped == '0) ? T_FINISH : T_READ;
                end
            end
            T_READ:   state_next = T_WAIT;
            T_WAIT:   state_next = T_KERN;
            T_KERN:
            begin
                if (term_valid)
                begin
                    state_next = last ? T_FINISH : T_READ;
                end
            end
            T_FINISH: if (!rsp_valid_reg || !rsp_stall) state_next = T_IDLE;
            default:  state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != T_IDLE);
        ram_we    = (state_reg == T_IDLE) && req_valid && (req.req_type == REQ_WRITE)
                    && (32'(req.particle_index) < 32'(MAX_PARTICLES));
        ram_addr  = (state_reg == T_IDLE) ? IDX_W'(32'(req.particle_index))
                                          : ptr_reg[IDX_W-1:0];
        k_start   = (state_reg == T_WAIT);
        rsp_load  = (state_reg == T_FINISH) && (!rsp_valid_reg || !rsp_stall);
        rsp_valid = rsp_valid_reg;
        rsp       = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= 11'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && accept && req.req_type == REQ_QUERY)
        begin
            qx_reg  <= req.pos_x;
            qy_reg  <= req.pos_y;
            n_reg   <= n_clamped;
            ptr_reg <= '0;
            acc_reg <= '0;
        end
        else if (state_reg == T_KERN && term_valid)
        begin
            acc_reg <= acc_reg + ACC_W'(term);
            ptr_reg <= ptr_reg + CNT_W'(1);
        end
        if (rsp_load)
        begin
            if (|(dens_wide >> 32))
            begin
                rsp_reg.density   <= 32'hFFFF_FFFF;
                rsp_reg.saturated <= 1'b1;
            end
            else
            begin
                rsp_reg.density   <= dens_wide[31:0];
                rsp_reg.saturated <= 1'b0;
            end
        end
    end

    sgd_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_PARTICLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sgd_kernel u_kernel (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (k_start),
        .entry      (ram_rdata),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .term_valid (term_valid),
        .term       (term)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        term_valid |-> state_reg == T_KERN)
        else $error("kernel term arrived outside the summation state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_READ || state_reg == T_WAIT || state_reg == T_KERN)
        |-> ptr_reg < n_reg)
        else $error("table pointer ran past the particle count");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == T_IDLE && !req_stall)
        else $error("table written while a query was in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.saturated |-> rsp.density == 32'hFFFF_FFFF)
        else $error("saturated response without clamped density");

endmodule
